/* hdl/assert_macros.svh */
// Assertion macros shared by the smoother RTL.
// Included by msm_window; the top level also uses its macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define MSM_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define MSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MSM_ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define MSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

/* hdl/msm_pkg.sv */
// Types and constants of the median and lowpass smoother.
// No dependencies; used by msm_window, msm_lowpass and the top level.
package msm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COEFF_W  = 17;
    localparam int SIZE_W   = 6;
    localparam int CMD_W    = 2;
    localparam int CHAN_W   = 4;

    localparam logic [COEFF_W-1:0] COEFF_ONE = 17'd65536;

    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SIZE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_COEFF  = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // One pass over a sorted window: optionally drop one copy of old_val,
    // then insert new_val.
    typedef struct packed {
        logic    del;
        sample_t old_val;
        sample_t new_val;
    } pass_req_t;

endpackage

/* hdl/msm_window.sv */
// Sorted window memory of all channels and its single-pass update engine.
// Depends on msm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module msm_window #(
    parameter int CHANNELS   = 16,
    parameter int MAX_WINDOW = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     start,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] ch,
    input  logic [$clog2(MAX_WINDOW + 1)-1:0]        n_old,
    input  msm_pkg::pass_req_t                       req,
    output logic                                     done,
    output msm_pkg::sample_t                         med_lo,
    output msm_pkg::sample_t                         med_hi
);

    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = CHANNELS << IW;

    msm_pkg::sample_t mem [DEPTH];

    logic                 busy_reg;
    logic [CHW-1:0]       ch_reg;
    logic [CW-1:0]        n_old_reg;
    logic [CW-1:0]        n_new_reg;
    logic [CW-1:0]        mi_reg;
    msm_pkg::pass_req_t   req_reg;
    logic [CW-1:0]        rd_cnt_reg;
    logic                 rvalid_reg;
    msm_pkg::sample_t     rdata_reg;
    logic [CW-1:0]        proc_cnt_reg;
    logic                 removed_reg;
    logic                 inserted_reg;
    logic [CW-1:0]        wr_pos_reg;
    msm_pkg::sample_t     q_reg [4];
    logic [1:0]           q_cnt_reg;
    msm_pkg::sample_t     med_lo_reg;
    msm_pkg::sample_t     med_hi_reg;

    msm_pkg::sample_t     q_next [4];
    logic [1:0]           q_cnt_next;
    logic                 removed_next;
    logic                 inserted_next;
    logic                 rd_go;
    logic                 skip;
    logic                 flush;
    logic [CW-1:0]        n_new_calc;

    assign n_new_calc = n_old - CW'(req.del) + CW'(1);
    assign rd_go      = busy_reg && (rd_cnt_reg < n_old_reg);
    assign flush      = busy_reg && !rvalid_reg && (proc_cnt_reg == n_old_reg) && !inserted_reg;
    assign skip       = rvalid_reg && req_reg.del && !removed_reg &&
                        ((rdata_reg == req_reg.old_val) ||
                         (proc_cnt_reg == n_old_reg - CW'(1)));
    assign done       = busy_reg && !rvalid_reg && (proc_cnt_reg == n_old_reg) &&
                        inserted_reg && (q_cnt_reg == 2'd0);
    assign med_lo     = med_lo_reg;
    assign med_hi     = med_hi_reg;

    // The queue absorbs the extra word that the insertion produces until the
    // dropped entry frees a slot again.
    always_comb
    begin
        q_next        = q_reg;
        q_cnt_next    = q_cnt_reg;
        removed_next  = removed_reg || skip;
        inserted_next = inserted_reg;
        if (q_cnt_next != 2'd0)
        begin
            q_next[0]  = q_next[1];
            q_next[1]  = q_next[2];
            q_next[2]  = q_next[3];
            q_cnt_next = q_cnt_next - 2'd1;
        end
        if (rvalid_reg && !skip)
        begin
            if (!inserted_reg && (rdata_reg > req_reg.new_val))
            begin
                q_next[q_cnt_next] = req_reg.new_val;
                q_cnt_next         = q_cnt_next + 2'd1;
                inserted_next      = 1'b1;
            end
            q_next[q_cnt_next] = rdata_reg;
            q_cnt_next         = q_cnt_next + 2'd1;
        end
        if (flush)
        begin
            q_next[q_cnt_next] = req_reg.new_val;
            q_cnt_next         = q_cnt_next + 2'd1;
            inserted_next      = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            rvalid_reg   <= 1'b0;
            q_cnt_reg    <= 2'd0;
            removed_reg  <= 1'b0;
            inserted_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            proc_cnt_reg <= '0;
            wr_pos_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg     <= 1'b1;
            rvalid_reg   <= 1'b0;
            q_cnt_reg    <= 2'd0;
            removed_reg  <= 1'b0;
            inserted_reg <= 1'b0;
            rd_cnt_reg   <= '0;
            proc_cnt_reg <= '0;
            wr_pos_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rvalid_reg   <= rd_go;
            q_cnt_reg    <= q_cnt_next;
            removed_reg  <= removed_next;
            inserted_reg <= inserted_next;
            if (rd_go)
            begin
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            end
            if (rvalid_reg)
            begin
                proc_cnt_reg <= proc_cnt_reg + CW'(1);
            end
            if (q_cnt_reg != 2'd0)
            begin
                wr_pos_reg <= wr_pos_reg + CW'(1);
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ch_reg    <= ch;
            n_old_reg <= n_old;
            n_new_reg <= n_new_calc;
            mi_reg    <= (n_new_calc - CW'(1)) >> 1;
            req_reg   <= req;
        end
        q_reg <= q_next;
        if (rd_go)
        begin
            rdata_reg <= mem[{ch_reg, rd_cnt_reg[IW-1:0]}];
        end
        if (busy_reg && (q_cnt_reg != 2'd0))
        begin
            mem[{ch_reg, wr_pos_reg[IW-1:0]}] <= q_reg[0];
            if (wr_pos_reg == mi_reg)
            begin
                med_lo_reg <= q_reg[0];
            end
            if (wr_pos_reg == mi_reg + CW'(1))
            begin
                med_hi_reg <= q_reg[0];
            end
        end
    end

    `MSM_ASSERT_NEVER(a_queue_depth, clk, rst_n, q_cnt_reg == 2'd3, "sort queue overflow")
    `MSM_ASSERT_NEVER(a_start_busy, clk, rst_n, start && busy_reg, "pass started while busy")
    `MSM_ASSERT_PROP(a_full_write, clk, rst_n, done |-> (wr_pos_reg == n_new_reg), "short pass")

endmodule

/* hdl/msm_lowpass.sv */
// One-pole lowpass datapath: two registered products, then sum and shift.
// Depends on msm_pkg.
module msm_lowpass (
    input  logic                          clk,
    input  logic                          mul_en,
    input  logic [msm_pkg::COEFF_W-1:0]   coeff,
    input  msm_pkg::sample_t              med,
    input  msm_pkg::sample_t              y_old,
    output msm_pkg::sample_t              y_new
);

    logic signed [49:0] prod_a_reg;
    logic signed [49:0] prod_b_reg;
    logic signed [50:0] acc;
    logic [msm_pkg::COEFF_W-1:0] coeff_inv;

    assign coeff_inv = msm_pkg::COEFF_ONE - coeff;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_a_reg <= $signed({1'b0, coeff}) * med;
            prod_b_reg <= $signed({1'b0, coeff_inv}) * y_old;
        end
    end

    // Bits 47:16 of the sum are the floored shift by 16, wrapped to 32 bits.
    assign acc   = 51'(prod_a_reg) + 51'(prod_b_reg);
    assign y_new = acc[47:16];

endmodule

/* hdl/median_lowpass_smoother_unit.sv */
// Top level of the multichannel running-median and lowpass smoother.
// Depends on msm_pkg, msm_window, msm_lowpass and assert_macros.svh.
//
// Input words arrive on s_tvalid/s_tready; s_tuser carries the command and
// channel, s_tdata the sample, window size and coefficient. A sample word
// for an existing channel produces one result word on m_tvalid/m_tready with
// the channel in m_tuser and the smoothed value in m_tdata. Clear, resize and
// coefficient words produce no result. env_mode is written through cfg_we/cfg_wdata.
// A sample word first reads the channel's history; the sorted-window memory
// port then walks every live entry of the filled window once and drains,
// after which the lowpass products are formed and summed before the unit
// returns to idle. Clear and coefficient words are applied in idle. A
// shrinking resize rebuilds the sorted window by insertion. One word is in
// work at a time. After reset all channels are empty with window 1 and
// coefficient 1.0, no clearing pass is needed. A finished result waits in
// the output register while the receiver stalls; the next word is still
// accepted and only its own result waits for it.
module median_lowpass_smoother_unit #(
    parameter int CHANNELS   = 16,
    parameter int MAX_WINDOW = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // env_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [5:0]  s_tuser,     // command[1:0], channel[5:2]
    input  logic [55:0] s_tdata,     // sample[31:0], new_size[37:32], new_coeff[54:38]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [3:0]  m_tuser,     // out_channel[3:0]
    output logic [31:0] m_tdata      // value[31:0]
);

    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int DEPTH = CHANNELS << IW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SETUP   = 4'd1;
    localparam logic [3:0] S_HWAIT   = 4'd2;
    localparam logic [3:0] S_PASS    = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_SUM     = 4'd5;
    localparam logic [3:0] S_RS_READ = 4'd6;
    localparam logic [3:0] S_RS_WAIT = 4'd7;
    localparam logic [3:0] S_RS_PASS = 4'd8;

    logic [3:0]                   state_reg;
    logic                         env_mode_reg;
    logic [CW-1:0]                fill_reg  [CHANNELS];
    logic [CW-1:0]                size_reg  [CHANNELS];
    logic [msm_pkg::COEFF_W-1:0]  coeff_reg [CHANNELS];
    msm_pkg::sample_t             fval_reg  [CHANNELS];
    logic [IW-1:0]                head_reg  [CHANNELS];

    msm_pkg::sample_t             hist_mem [DEPTH];
    msm_pkg::sample_t             hist_rdata_reg;

    logic [CHW-1:0]               ch_reg;
    logic [3:0]                   chan_reg;
    msm_pkg::sample_t             x_reg;
    logic                         del_reg;
    logic [CW-1:0]                pass_n_reg;
    logic [CW-1:0]                n_new_reg;
    logic [CW-1:0]                k_reg;
    logic [CW-1:0]                rs_n_reg;
    msm_pkg::sample_t             med_reg;
    logic                         env_hit_reg;
    logic                         m_tvalid_reg;
    logic [3:0]                   m_tuser_reg;
    msm_pkg::sample_t             m_tdata_reg;

    logic [1:0]                   in_cmd;
    logic [3:0]                   in_chan;
    logic [CHW-1:0]               in_ch;
    logic                         in_ch_ok;
    logic [msm_pkg::SIZE_W-1:0]   in_size;
    logic [msm_pkg::COEFF_W-1:0]  in_coeff;
    logic [CW-1:0]                size_fix;
    logic                         accept;
    logic [CW-1:0]                cur_fill;
    logic                         grow;
    logic                         hist_re;
    logic [IW-1:0]                hist_ridx;
    logic                         win_start;
    logic                         win_done;
    msm_pkg::pass_req_t           win_req;
    msm_pkg::sample_t             win_lo;
    msm_pkg::sample_t             win_hi;
    logic signed [32:0]           med_sum;
    msm_pkg::sample_t             lp_y;
    logic                         out_free;

    assign in_cmd   = s_tuser[1:0];
    assign in_chan  = s_tuser[5:2];
    assign in_ch    = CHW'(in_chan);
    assign in_ch_ok = 32'(in_chan) < CHANNELS;
    assign in_size  = s_tdata[37:32];
    assign in_coeff = s_tdata[54:38];
    assign size_fix = ((in_size != '0) && (32'(in_size) <= MAX_WINDOW)) ? CW'(in_size) : CW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign cur_fill = fill_reg[ch_reg];
    assign grow     = cur_fill < size_reg[ch_reg];

    // History entry i of a channel sits i places behind its head pointer.
    assign hist_re   = (state_reg == S_SETUP) ||
                       ((state_reg == S_RS_READ) && (k_reg != rs_n_reg));
    assign hist_ridx = (state_reg == S_SETUP) ?
                       IW'(head_reg[ch_reg] - IW'(cur_fill) + IW'(1)) :
                       IW'(head_reg[ch_reg] - IW'(k_reg));

    assign win_start       = (state_reg == S_HWAIT) || (state_reg == S_RS_WAIT);
    assign win_req.del     = (state_reg == S_HWAIT) && del_reg;
    assign win_req.old_val = hist_rdata_reg;
    assign win_req.new_val = (state_reg == S_HWAIT) ? x_reg : hist_rdata_reg;

    assign med_sum = 33'(win_lo) + 33'(win_hi);

    msm_window #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (win_start),
        .ch     (ch_reg),
        .n_old  (pass_n_reg),
        .req    (win_req),
        .done   (win_done),
        .med_lo (win_lo),
        .med_hi (win_hi)
    );

    msm_lowpass u_lowpass (
        .clk    (clk),
        .mul_en (state_reg == S_MUL),
        .coeff  (coeff_reg[ch_reg]),
        .med    (med_reg),
        .y_old  (fval_reg[ch_reg]),
        .y_new  (lp_y)
    );

    always_ff @(posedge clk)
    begin
        if (hist_re)
        begin
            hist_rdata_reg <= hist_mem[{ch_reg, hist_ridx}];
        end
        if (state_reg == S_HWAIT)
        begin
            hist_mem[{ch_reg, IW'(head_reg[ch_reg] + IW'(1))}] <= x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            env_mode_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                fill_reg[c]  <= '0;
                size_reg[c]  <= CW'(1);
                coeff_reg[c] <= msm_pkg::COEFF_ONE;
                fval_reg[c]  <= '0;
                head_reg[c]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                env_mode_reg <= cfg_wdata;
            end
            // In the sum step the output register is reloaded instead.
            if (m_tvalid_reg && m_tready && (state_reg != S_SUM))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_ch_ok)
                    begin
                        ch_reg   <= in_ch;
                        chan_reg <= in_chan;
                        x_reg    <= s_tdata[31:0];
                        unique case (in_cmd)
                            msm_pkg::CMD_SAMPLE:
                            begin
                                state_reg <= S_SETUP;
                            end
                            msm_pkg::CMD_CLEAR:
                            begin
                                fill_reg[in_ch] <= '0;
                                fval_reg[in_ch] <= '0;
                            end
                            msm_pkg::CMD_SIZE:
                            begin
                                size_reg[in_ch] <= size_fix;
                                if (fill_reg[in_ch] > size_fix)
                                begin
                                    fill_reg[in_ch] <= size_fix;
                                    k_reg           <= '0;
                                    rs_n_reg        <= size_fix;
                                    state_reg       <= S_RS_READ;
                                end
                            end
                            msm_pkg::CMD_COEFF:
                            begin
                                coeff_reg[in_ch] <= (in_coeff > msm_pkg::COEFF_ONE) ?
                                                    msm_pkg::COEFF_ONE : in_coeff;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SETUP:
                begin
                    pass_n_reg <= cur_fill;
                    del_reg    <= !grow && (cur_fill != '0);
                    if (grow || (cur_fill == '0))
                    begin
                        fill_reg[ch_reg] <= cur_fill + CW'(1);
                        n_new_reg        <= cur_fill + CW'(1);
                    end
                    else
                    begin
                        n_new_reg <= cur_fill;
                    end
                    state_reg <= S_HWAIT;
                end
                S_HWAIT:
                begin
                    head_reg[ch_reg] <= head_reg[ch_reg] + IW'(1);
                    state_reg        <= S_PASS;
                end
                S_PASS:
                begin
                    if (win_done)
                    begin
                        med_reg   <= n_new_reg[0] ? win_lo : med_sum[32:1];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    env_hit_reg <= env_mode_reg && (x_reg > fval_reg[ch_reg]);
                    state_reg   <= S_SUM;
                end
                S_SUM:
                begin
                    if (out_free)
                    begin
                        fval_reg[ch_reg] <= env_hit_reg ? med_reg : lp_y;
                        m_tdata_reg      <= env_hit_reg ? med_reg : lp_y;
                        m_tuser_reg      <= chan_reg;
                        m_tvalid_reg     <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                S_RS_READ:
                begin
                    pass_n_reg <= k_reg;
                    state_reg  <= (k_reg == rs_n_reg) ? S_IDLE : S_RS_WAIT;
                end
                S_RS_WAIT:
                begin
                    state_reg <= S_RS_PASS;
                end
                S_RS_PASS:
                begin
                    if (win_done)
                    begin
                        k_reg     <= k_reg + CW'(1);
                        state_reg <= S_RS_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `MSM_ASSERT_PROP(a_done_in_pass, clk, rst_n, win_done |-> ((state_reg == S_PASS) || (state_reg == S_RS_PASS)), "window pass ended outside a wait state")
    `MSM_ASSERT_PROP(a_fill_bound, clk, rst_n, (state_reg == S_SETUP) |-> (fill_reg[ch_reg] <= size_reg[ch_reg]), "fill count above window size")
    `MSM_ASSERT_PROP(a_result_source, clk, rst_n, $rose(m_tvalid_reg) |-> $past(state_reg == S_SUM), "result raised outside the sum step")

endmodule
